// ===== rtl/core/skvs_pkg.sv =====
// shared types, constants and helpers of the slot key/value store
package skvs_pkg;

  // fixed field widths
  localparam int KEY_W       = 64;
  localparam int VAL_W       = 64;
  localparam int LEN_W       = 4;
  localparam int OP_W        = 3;
  localparam int SIDX_W      = 4;
  localparam int COUNT_W     = 5;
  localparam int IN_TDATA_W  = 144;
  localparam int OUT_TDATA_W = 80;

  // parameter defaults
  localparam int SLOTS_DEF       = 16;
  localparam int KEY_BYTES_DEF   = 8;
  localparam int VALUE_BYTES_DEF = 8;

  // operation codes
  localparam logic [OP_W-1:0] OP_INSERT = 3'd0;
  localparam logic [OP_W-1:0] OP_DELETE = 3'd1;
  localparam logic [OP_W-1:0] OP_GET    = 3'd2;
  localparam logic [OP_W-1:0] OP_UPDATE = 3'd3;
  localparam logic [OP_W-1:0] OP_CLEAR  = 3'd4;

  typedef enum logic [1:0] {
    ST_OK,
    ST_DUPLICATE,
    ST_FULL,
    ST_NOT_FOUND
  } skvs_status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DONE
  } skvs_state_t;

  // registered read port of the slot store
  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [LEN_W-1:0] klen;
    logic [VAL_W-1:0] val;
    logic [LEN_W-1:0] vlen;
  } skvs_rd_t;

  // write and occupancy command to the slot store
  typedef struct packed {
    logic             wr_key;
    logic             wr_val;
    logic             set_valid;
    logic             clr_valid;
    logic             clr_all;
    logic [KEY_W-1:0] key;
    logic [LEN_W-1:0] klen;
    logic [VAL_W-1:0] val;
    logic [LEN_W-1:0] vlen;
  } skvs_wcmd_t;

  // one finished result
  typedef struct packed {
    skvs_status_t       status;
    logic [VAL_W-1:0]   fval;
    logic [LEN_W-1:0]   flen;
    logic [SIDX_W-1:0]  sidx;
    logic [COUNT_W-1:0] count;
  } skvs_res_t;

  // keeps the low n bytes of a 64-bit word
  function automatic logic [KEY_W-1:0] byte_mask(input logic [LEN_W-1:0] n);
    logic [KEY_W-1:0] m;
    m = '0;
    for (int i = 0; i < KEY_W / 8; i++) begin
      if (LEN_W'(i) < n) begin
        m[8*i +: 8] = 8'hFF;
      end
    end
    return m;
  endfunction

endpackage

// ===== rtl/core/slot_key_value_store.sv =====
// top level of the slot key/value store: stream ports and output register
//
// channel | direction | handshake               | payload
// in_     | slave     | in_tvalid / in_tready   | in_tdata: request item
// out_    | master    | out_tvalid / out_tready | out_tdata: result item
//
// an insert, delete, get or update item runs the full slot scan from accept
// to the next accept when no slot matches; a match stops the scan early.
// the scan reads the slot memories through their single registered read
// port, one slot per cycle, feeding one shared key comparator.
// reset frees every slot at once through per-slot occupancy flags.
// a new item is taken while a result waits in the output register; the next
// result holds in the sequencer until that register is free.
module slot_key_value_store
  import skvs_pkg::*;
#(
  parameter int SLOTS       = SLOTS_DEF,
  parameter int KEY_BYTES   = KEY_BYTES_DEF,
  parameter int VALUE_BYTES = VALUE_BYTES_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // operation[2:0], key[66:3], key_length[70:67], value[134:71],
  // value_length[138:135], zero fill[143:139]
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // status[1:0], found_value[65:2], found_value_length[69:66],
  // slot_index[73:70], entry_count[78:74], zero fill[79]
  output logic [OUT_TDATA_W-1:0] out_tdata
);

  localparam int IW = SLOTS > 1 ? $clog2(SLOTS) : 1;

  logic [IW-1:0]    rd_addr;
  logic [IW-1:0]    wr_addr;
  skvs_rd_t         rd_data;
  skvs_wcmd_t       wr;
  logic [SLOTS-1:0] valid;
  logic             res_valid;
  logic             res_ready;
  skvs_res_t        res;

  logic                   out_valid_r;
  logic [OUT_TDATA_W-1:0] out_data_r;

  skvs_store #(
    .SLOTS(SLOTS)
  ) u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_addr (wr_addr),
    .wr      (wr),
    .valid   (valid)
  );

  skvs_seq #(
    .SLOTS       (SLOTS),
    .KEY_BYTES   (KEY_BYTES),
    .VALUE_BYTES (VALUE_BYTES)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_op     (in_tdata[2:0]),
    .in_key    (in_tdata[66:3]),
    .in_klen   (in_tdata[70:67]),
    .in_val    (in_tdata[134:71]),
    .in_vlen   (in_tdata[138:135]),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data),
    .wr_addr   (wr_addr),
    .wr        (wr),
    .valid     (valid),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  // output register, free when empty or being taken
  assign res_ready = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  // result packing
  always_ff @(posedge clk) begin
    if (res_valid) begin
      out_data_r <= {1'b0, res.count, res.sidx, res.flen, res.fval, res.status};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

// ===== rtl/core/skvs_store.sv =====
// slot store: key and value memories with registered read, occupancy flags
module skvs_store
  import skvs_pkg::*;
#(
  parameter int SLOTS = SLOTS_DEF
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic [(SLOTS > 1 ? $clog2(SLOTS) : 1)-1:0] rd_addr,
  output skvs_rd_t                                rd_data,
  input  logic [(SLOTS > 1 ? $clog2(SLOTS) : 1)-1:0] wr_addr,
  input  skvs_wcmd_t                              wr,
  output logic [SLOTS-1:0]                        valid
);

  logic [KEY_W-1:0] key_mem  [SLOTS];
  logic [LEN_W-1:0] klen_mem [SLOTS];
  logic [VAL_W-1:0] val_mem  [SLOTS];
  logic [LEN_W-1:0] vlen_mem [SLOTS];

  skvs_rd_t         rd_data_r;
  logic [SLOTS-1:0] valid_r;

  // memory writes and registered read
  always_ff @(posedge clk) begin
    if (wr.wr_key) begin
      key_mem[wr_addr]  <= wr.key;
      klen_mem[wr_addr] <= wr.klen;
    end
    if (wr.wr_val) begin
      val_mem[wr_addr]  <= wr.val;
      vlen_mem[wr_addr] <= wr.vlen;
    end
    rd_data_r.key  <= key_mem[rd_addr];
    rd_data_r.klen <= klen_mem[rd_addr];
    rd_data_r.val  <= val_mem[rd_addr];
    rd_data_r.vlen <= vlen_mem[rd_addr];
  end

  // occupancy flags, cleared at once by reset or clear
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (wr.clr_all) begin
      valid_r <= '0;
    end else begin
      if (wr.set_valid) begin
        valid_r[wr_addr] <= 1'b1;
      end
      if (wr.clr_valid) begin
        valid_r[wr_addr] <= 1'b0;
      end
    end
  end

  assign rd_data = rd_data_r;
  assign valid   = valid_r;

endmodule

// ===== rtl/core/skvs_seq.sv =====
// sequencer: slot scan with one shared key compare, then at most one write-back
module skvs_seq
  import skvs_pkg::*;
#(
  parameter int SLOTS       = SLOTS_DEF,
  parameter int KEY_BYTES   = KEY_BYTES_DEF,
  parameter int VALUE_BYTES = VALUE_BYTES_DEF
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    in_valid,
  output logic                                    in_ready,
  input  logic [OP_W-1:0]                         in_op,
  input  logic [KEY_W-1:0]                        in_key,
  input  logic [LEN_W-1:0]                        in_klen,
  input  logic [VAL_W-1:0]                        in_val,
  input  logic [LEN_W-1:0]                        in_vlen,
  output logic [(SLOTS > 1 ? $clog2(SLOTS) : 1)-1:0] rd_addr,
  input  skvs_rd_t                                rd_data,
  output logic [(SLOTS > 1 ? $clog2(SLOTS) : 1)-1:0] wr_addr,
  output skvs_wcmd_t                              wr,
  input  logic [SLOTS-1:0]                        valid,
  output logic                                    res_valid,
  input  logic                                    res_ready,
  output skvs_res_t                               res
);

  localparam int IW = SLOTS > 1 ? $clog2(SLOTS) : 1;
  localparam int CW = $clog2(SLOTS + 1);
  localparam logic [LEN_W-1:0] KB_L = LEN_W'(KEY_BYTES);
  localparam logic [LEN_W-1:0] VB_L = LEN_W'(VALUE_BYTES);
  localparam logic [CW-1:0]    SLOTS_C = CW'(SLOTS);

  skvs_state_t      state_r, state_nxt;
  logic [OP_W-1:0]  op_r, op_nxt;
  logic [KEY_W-1:0] key_r, key_nxt;
  logic [LEN_W-1:0] klen_r, klen_nxt;
  logic [VAL_W-1:0] val_r, val_nxt;
  logic [LEN_W-1:0] vlen_r, vlen_nxt;
  logic [CW-1:0]    scan_r, scan_nxt;
  logic             pend_r, pend_nxt;
  logic [IW-1:0]    pend_idx_r, pend_idx_nxt;
  logic             free_found_r, free_found_nxt;
  logic [IW-1:0]    free_idx_r, free_idx_nxt;
  logic             hit_r, hit_nxt;
  logic [IW-1:0]    hit_idx_r, hit_idx_nxt;
  logic [VAL_W-1:0] hit_val_r, hit_val_nxt;
  logic [LEN_W-1:0] hit_vlen_r, hit_vlen_nxt;
  logic [CW-1:0]    count_r, count_nxt;

  logic             match;
  logic [LEN_W-1:0] kl_norm;
  logic [LEN_W-1:0] vl_norm;
  logic [IW-1:0]    res_idx;

  // shared compare unit: stored slot against the request key
  assign match = pend_r && valid[pend_idx_r] && (rd_data.klen == klen_r) &&
                 (rd_data.key == key_r);

  // request length clamping
  always_comb begin
    kl_norm = in_klen;
    if (in_klen == '0) begin
      kl_norm = LEN_W'(1);
    end else if (in_klen > KB_L) begin
      kl_norm = KB_L;
    end
    vl_norm = (in_vlen > VB_L) ? VB_L : in_vlen;
  end

  // state and datapath registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    key_r        <= key_nxt;
    klen_r       <= klen_nxt;
    val_r        <= val_nxt;
    vlen_r       <= vlen_nxt;
    scan_r       <= scan_nxt;
    pend_r       <= pend_nxt;
    pend_idx_r   <= pend_idx_nxt;
    free_found_r <= free_found_nxt;
    free_idx_r   <= free_idx_nxt;
    hit_r        <= hit_nxt;
    hit_idx_r    <= hit_idx_nxt;
    hit_val_r    <= hit_val_nxt;
    hit_vlen_r   <= hit_vlen_nxt;
  end

  // next state and outputs
  always_comb begin
    state_nxt      = state_r;
    op_nxt         = op_r;
    key_nxt        = key_r;
    klen_nxt       = klen_r;
    val_nxt        = val_r;
    vlen_nxt       = vlen_r;
    scan_nxt       = scan_r;
    pend_nxt       = pend_r;
    pend_idx_nxt   = pend_idx_r;
    free_found_nxt = free_found_r;
    free_idx_nxt   = free_idx_r;
    hit_nxt        = hit_r;
    hit_idx_nxt    = hit_idx_r;
    hit_val_nxt    = hit_val_r;
    hit_vlen_nxt   = hit_vlen_r;
    count_nxt      = count_r;

    in_ready   = 1'b0;
    res_valid  = 1'b0;
    rd_addr    = scan_r[IW-1:0];
    wr         = '0;
    wr.key     = key_r;
    wr.klen    = klen_r;
    wr.val     = val_r;
    wr.vlen    = vlen_r;
    res_idx    = '0;
    res        = '0;
    res.status = ST_OK;
    wr_addr    = (op_r == OP_INSERT) ? free_idx_r : hit_idx_r;

    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          op_nxt         = in_op;
          klen_nxt       = kl_norm;
          key_nxt        = in_key & byte_mask(kl_norm);
          vlen_nxt       = vl_norm;
          val_nxt        = in_val & byte_mask(vl_norm);
          scan_nxt       = '0;
          pend_nxt       = 1'b0;
          free_found_nxt = 1'b0;
          hit_nxt        = 1'b0;
          unique case (in_op) inside
            OP_INSERT, OP_DELETE, OP_GET, OP_UPDATE: state_nxt = S_SCAN;
            default:                                 state_nxt = S_DONE;
          endcase
        end
      end

      S_SCAN: begin
        // issue the next slot read and note the lowest free slot
        pend_nxt = 1'b0;
        if ((scan_r != SLOTS_C) && !match) begin
          pend_nxt     = 1'b1;
          pend_idx_nxt = scan_r[IW-1:0];
          scan_nxt     = scan_r + CW'(1);
          if (!free_found_r && !valid[scan_r[IW-1:0]]) begin
            free_found_nxt = 1'b1;
            free_idx_nxt   = scan_r[IW-1:0];
          end
        end
        // compare result of the slot read issued in the previous cycle
        if (match) begin
          hit_nxt      = 1'b1;
          hit_idx_nxt  = pend_idx_r;
          hit_val_nxt  = rd_data.val;
          hit_vlen_nxt = rd_data.vlen;
          state_nxt    = S_DONE;
        end else if (scan_r == SLOTS_C) begin
          state_nxt = S_DONE;
        end
      end

      S_DONE: begin
        if (res_ready) begin
          res_valid = 1'b1;
          state_nxt = S_IDLE;
          case (op_r)
            OP_INSERT: begin
              if (hit_r) begin
                res.status = ST_DUPLICATE;
              end else if (!free_found_r) begin
                res.status = ST_FULL;
              end else begin
                wr.wr_key    = 1'b1;
                wr.wr_val    = 1'b1;
                wr.set_valid = 1'b1;
                count_nxt    = count_r + CW'(1);
                res_idx      = free_idx_r;
              end
            end
            OP_DELETE: begin
              if (hit_r) begin
                wr.clr_valid = 1'b1;
                if (count_r != '0) begin
                  count_nxt = count_r - CW'(1);
                end
                res_idx = hit_idx_r;
              end else begin
                res.status = ST_NOT_FOUND;
              end
            end
            OP_GET: begin
              if (hit_r) begin
                res.fval = hit_val_r;
                res.flen = hit_vlen_r;
                res_idx  = hit_idx_r;
              end else begin
                res.status = ST_NOT_FOUND;
              end
            end
            OP_UPDATE: begin
              if (hit_r) begin
                wr.wr_val = 1'b1;
                res_idx   = hit_idx_r;
              end else begin
                res.status = ST_NOT_FOUND;
              end
            end
            OP_CLEAR: begin
              wr.clr_all = 1'b1;
              count_nxt  = '0;
            end
            default: begin
            end
          endcase
          res.sidx  = SIDX_W'(res_idx);
          res.count = COUNT_W'(count_nxt);
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // live count never exceeds the table size
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= SLOTS_C)
    else $error("entry count above slot count");

  // live count tracks the occupancy flags
  a_count_flags: assert property (@(posedge clk) disable iff (!rst_n)
    count_r == CW'($countones(valid)))
    else $error("entry count differs from occupied slots");

  // an accepted item closes the input until its result is passed to the output register
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input open right after accepting an item");

  // a recorded hit always names an occupied slot until write-back
  a_hit_occupied: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE && hit_r) |-> valid[hit_idx_r])
    else $error("hit on a free slot");

endmodule
